// File: design/sorted_list_intersection_top_macros.svh
// Assertion macros used by the checker file.
`ifndef SORTED_LIST_INTERSECTION_TOP_MACROS_SVH
`define SORTED_LIST_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define SLI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define SLI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches the reset cycles.
`define SLI_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sli_pkg.sv
`timescale 1ns / 1ps
package sli_pkg;

    localparam int LIST_DEPTH  = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(LIST_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int COUNT_W     = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_PROBE  = 2'd2;

    // result tdata: match_value, match_count, zero fill to whole bytes
    localparam int M_TDATA_W = ((VALUE_WIDTH + COUNT_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_WIDTH - COUNT_W;

    typedef struct packed {
        logic                   en;
        logic [ADDR_W-1:0]      addr;
        logic [VALUE_WIDTH-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic                   matched;
        logic [VALUE_WIDTH-1:0] value;
        logic [COUNT_W-1:0]     count;
        logic                   last;
        logic                   ovf;
    } res_t;

endpackage

// File: design/sli_list_mem.sv
`timescale 1ns / 1ps
module sli_list_mem (
    input  logic                           aclk,
    input  sli_pkg::mem_wr_t               wr,
    input  logic [sli_pkg::ADDR_W-1:0]     rd_addr,
    output logic [sli_pkg::VALUE_WIDTH-1:0] rd_data
);
    import sli_pkg::*;

    logic [VALUE_WIDTH-1:0] mem [LIST_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/sli_merge_ctrl.sv
`timescale 1ns / 1ps
module sli_merge_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sli_pkg::OP_W-1:0]        in_op,
    input  logic [sli_pkg::VALUE_WIDTH-1:0] in_value,
    input  logic                            in_last,
    output sli_pkg::mem_wr_t                mem_wr,
    output logic [sli_pkg::ADDR_W-1:0]      mem_rd_addr,
    input  logic [sli_pkg::VALUE_WIDTH-1:0] mem_rd_data,
    output sli_pkg::res_t                   res,
    output logic                            res_valid,
    input  logic                            out_free
);
    import sli_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       ptr_reg, ptr_next;
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;
    logic                   hit_reg, hit_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic                   last_reg, last_next;

    logic [LEN_W-1:0] ptr_inc;
    logic             lt, eq;

    // the one shared comparator
    assign lt = mem_rd_data < val_reg;
    assign eq = mem_rd_data == val_reg;
    assign ptr_inc = ptr_reg + LEN_W'(1);

    assign in_ready    = (state_reg == ST_IDLE);
    assign mem_rd_addr = ptr_reg[ADDR_W-1:0];

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        hit_next   = hit_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        mem_wr     = '{en: 1'b0, addr: len_reg[ADDR_W-1:0], data: in_value};
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_op)
                        OP_CLEAR: begin
                            len_next = '0;
                            ptr_next = '0;
                            cnt_next = '0;
                            ovf_next = 1'b0;
                        end
                        OP_APPEND: begin
                            if (len_reg < LEN_W'(LIST_DEPTH)) begin
                                mem_wr.en = 1'b1;
                                len_next  = len_reg + LEN_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_PROBE: begin
                            val_next  = in_value;
                            last_next = in_last;
                            hit_next  = 1'b0;
                            // read of list[ptr] is already under way
                            state_next = (ptr_reg < len_reg) ? ST_CMP : ST_OUT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP: begin
                if (lt) begin
                    ptr_next   = ptr_inc;
                    state_next = (ptr_inc < len_reg) ? ST_RD : ST_OUT;
                end else if (eq) begin
                    hit_next   = 1'b1;
                    ptr_next   = ptr_inc;
                    if (cnt_reg != COUNT_MAX) begin
                        cnt_next = cnt_reg + COUNT_W'(1);
                    end
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
        hit_reg  <= hit_next;
        val_reg  <= val_next;
        last_reg <= last_next;
    end

    assign res_valid = (state_reg == ST_OUT);
    assign res = '{matched: hit_reg,
                   value:   hit_reg ? val_reg : '0,
                   count:   cnt_reg,
                   last:    last_reg,
                   ovf:     ovf_reg};

endmodule

// File: design/sorted_list_intersection_top.sv
// Timing: clear and append are taken in the idle state. A probe goes from idle straight to
// the output state when list A is exhausted, else through a compare, then a read and a
// compare per pointer step; from there the result enters the output register that drives
// m_tvalid, and a result held in the output slot stalls the sequencer. Pointer steps over
// A total at most its length between clears; no new request is taken until a probe's result
// has left the sequencer. Each step is the registered read of the single list memory and one compare.
// Reset: aresetn sync, active low; empties A, clears ptr, count, ovf; no memory sweep.
`timescale 1ns / 1ps
module sorted_list_intersection_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sli_pkg::VALUE_WIDTH-1:0] s_tdata,   // [31:0] item_value
    input  logic [sli_pkg::OP_W-1:0]        s_tuser,   // [1:0] opcode
    input  logic                            s_tlast,   // last_probe
    // result side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sli_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] match_value,
                                                       // [42:32] match_count, [47:43] zero
    output logic [1:0]                      m_tuser,   // [0] matched, [1] overflowed
    output logic                            m_tlast    // list_end
);
    import sli_pkg::*;

    mem_wr_t                mem_wr;
    logic [ADDR_W-1:0]      mem_rd_addr;
    logic [VALUE_WIDTH-1:0] mem_rd_data;
    res_t                   res;
    logic                   res_valid;
    logic                   out_free;

    // output register: holds one finished result while the sequencer goes on
    logic                   m_tvalid_reg;
    res_t                   out_reg;

    // list A storage, one write and one registered read per cycle
    sli_list_mem u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // sequencer: list bookkeeping, merge pointer, shared comparator
    sli_merge_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_value    (s_tdata),
        .in_last     (s_tlast),
        .mem_wr      (mem_wr),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res         (res),
        .res_valid   (res_valid),
        .out_free    (out_free)
    );

    // slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res_valid;
        end
        if (out_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg.count, out_reg.value};
    assign m_tuser  = {out_reg.ovf, out_reg.matched};
    assign m_tlast  = out_reg.last;

endmodule

// File: design/sli_checker.sv
`timescale 1ns / 1ps
`include "sorted_list_intersection_top_macros.svh"
module sli_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [sli_pkg::OP_W-1:0]        s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sli_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [1:0]                      m_tuser
);
    import sli_pkg::*;

    // a stalled result stays offered
    `SLI_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // a probe keeps the sequencer busy once it is taken
    `SLI_ASSERT_NXT(a_probe_busy, s_tvalid && s_tready && (s_tuser == OP_PROBE), !s_tready,
        "request taken during probe")

    // a miss reports a zero document id
    `SLI_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata[VALUE_WIDTH-1:0] == '0,
        "nonzero value on miss")

    // nothing is offered right after reset
    `SLI_ASSERT_RST(a_rst_empty, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind sorted_list_intersection_top sli_checker u_sli_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import sli_pkg::*;

    // opcode 3 has no meaning in the block; it must be swallowed silently
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS     = 400;
    localparam int RUN_MAX          = 24;
    localparam int CYCLE_LIMIT      = 800000;
    localparam int SHOWN_MISMATCHES = 10;

    // Tracks list A exactly as the block should and queues one expected
    // result per probe request, in order.
    class intersect_sb;
        logic [VALUE_WIDTH-1:0] list_a [LIST_DEPTH];
        int unsigned            a_len = 0;
        int unsigned            scan_ptr = 0;
        logic [COUNT_W-1:0]     hit_total = '0;
        logic                   drop_seen = 1'b0;
        res_t                   pending_hits [$];
        int unsigned            mismatches = 0;

        function string fmt_res(res_t r);
            return $sformatf("matched=%0b value=%h count=%0d last=%0b ovf=%0b",
                             r.matched, r.value, r.count, r.last, r.ovf);
        endfunction

        function void report(string what, res_t want, res_t got);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES) begin
                $display("%0t: %s", $time, what);
                $display("    expected %s", fmt_res(want));
                $display("    actual   %s", fmt_res(got));
            end
        endfunction

        function void take_request(logic [OP_W-1:0] op, logic [VALUE_WIDTH-1:0] v,
                                   logic lst);
            res_t r;
            case (op)
                OP_CLEAR: begin
                    a_len     = 0;
                    scan_ptr  = 0;
                    hit_total = '0;
                    drop_seen = 1'b0;
                end
                OP_APPEND: begin
                    if (a_len < LIST_DEPTH) begin
                        list_a[a_len] = v;
                        a_len++;
                    end else begin
                        drop_seen = 1'b1;
                    end
                end
                OP_PROBE: begin
                    // merge step: skip entries below the probe, hit on equality
                    while (scan_ptr < a_len && list_a[scan_ptr] < v)
                        scan_ptr++;
                    r = '0;
                    if (scan_ptr < a_len && list_a[scan_ptr] == v) begin
                        r.matched = 1'b1;
                        r.value   = v;
                        scan_ptr++;
                        if (hit_total != COUNT_MAX)
                            hit_total++;
                    end
                    r.count = hit_total;
                    r.last  = lst;
                    r.ovf   = drop_seen;
                    pending_hits.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [1:0] user,
                                   logic lst);
            res_t got;
            res_t want;
            got.matched = user[0];
            got.ovf     = user[1];
            got.value   = data[VALUE_WIDTH-1:0];
            got.count   = data[VALUE_WIDTH +: COUNT_W];
            got.last    = lst;
            if (pending_hits.size() == 0) begin
                report("result with no probe outstanding", '0, got);
                return;
            end
            want = pending_hits.pop_front();
            if (got.matched !== want.matched || got.value !== want.value ||
                got.count !== want.count || got.last !== want.last ||
                got.ovf !== want.ovf)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [VALUE_WIDTH-1:0] s_tdata  = '0;
    logic [OP_W-1:0]        s_tuser  = OP_CLEAR;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    // idle odds in percent, changed by the stimulus as it goes
    int          send_idle = 25;
    int          recv_idle = 86;
    int unsigned fed_items = 0;
    int unsigned cycles    = 0;
    intersect_sb sb = new;

    sorted_list_intersection_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: sample the handshake as it stood at the edge, then pick
    // the next ready value.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid === 1'b1 && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // One request; returns right after the edge that accepted it.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [VALUE_WIDTH-1:0] v,
                            input logic lst);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= v;
        s_tlast  <= lst;
        @(posedge aclk);
        while (s_tready !== 1'b1)
            @(posedge aclk);
        sb.take_request(op, v, lst);
        if (op != OP_UNUSED)
            fed_items++;
    endtask

    // Stop sending until every probe has been answered.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_hits.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [VALUE_WIDTH-1:0] run_a  [RUN_MAX];
        logic [VALUE_WIDTH-1:0] full_a [LIST_DEPTH];
        longint unsigned        acc;
        int unsigned            rand_start;
        int                     n;
        int                     m;
        int                     k;
        int                     sel;
        int                     idx;
        logic [VALUE_WIDTH-1:0] pv;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty list, ignored opcode, extremes, duplicates
        send_req(OP_PROBE, '0, 1'b0);
        send_req(OP_UNUSED, '1, 1'b1);
        send_req(OP_APPEND, '0, 1'b0);
        send_req(OP_APPEND, 32'd7, 1'b1);
        send_req(OP_APPEND, 32'd7, 1'b0);
        send_req(OP_APPEND, '1, 1'b0);
        send_req(OP_PROBE, '0, 1'b0);
        send_req(OP_PROBE, 32'd7, 1'b0);
        send_req(OP_PROBE, 32'd7, 1'b0);
        send_req(OP_PROBE, 32'd8, 1'b0);
        send_req(OP_PROBE, '1, 1'b1);
        // past the end of A; last flag must not rewind
        send_req(OP_PROBE, '1, 1'b0);
        send_req(OP_CLEAR, '1, 1'b1);
        send_req(OP_PROBE, 32'd5, 1'b0);
        // unsorted list: compared as stored
        send_req(OP_APPEND, 32'd10, 1'b0);
        send_req(OP_APPEND, 32'd5, 1'b0);
        send_req(OP_APPEND, 32'd20, 1'b0);
        send_req(OP_PROBE, 32'd5, 1'b0);
        send_req(OP_PROBE, 32'd20, 1'b1);
        // append behind the pointer after probing
        send_req(OP_APPEND, 32'd1, 1'b0);
        send_req(OP_PROBE, 32'd1, 1'b0);
        drain();

        // random: mostly clean clear/load/probe runs, some noise
        rand_start = fed_items;
        while (fed_items - rand_start < RANDOM_ITEMS) begin
            if (fed_items - rand_start >= 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (fed_items - rand_start >= RANDOM_ITEMS / 3) begin
                send_idle = 86;
                recv_idle = 25;
            end

            if ($urandom_range(9) < 8) begin
                send_req(OP_CLEAR, $urandom, 1'($urandom_range(1)));
                case ($urandom_range(3))
                    0:       acc = 64'($urandom_range(200));
                    1:       acc = 64'hFFFF_FFFF - $urandom_range(150);
                    default: acc = 64'($urandom);
                endcase
                n = $urandom_range(1, RUN_MAX);
                for (int i = 0; i < n; i++) begin
                    if (acc > 64'hFFFF_FFFF) begin
                        n = i;
                        break;
                    end
                    run_a[i] = acc[VALUE_WIDTH-1:0];
                    send_req(OP_APPEND, run_a[i], 1'($urandom_range(1)));
                    // an occasional zero step gives duplicate ids
                    if ($urandom_range(9) != 0)
                        acc += $urandom_range(1, 6);
                end
                m = $urandom_range(1, RUN_MAX);
                k = 0;
                for (int j = 0; j < m; j++) begin
                    if (k >= n) begin
                        pv = run_a[n-1] + $urandom_range(1, 5);
                    end else begin
                        sel = $urandom_range(9);
                        if (sel < 6)
                            pv = run_a[k];
                        else if (sel < 8)
                            pv = run_a[k] + 1;
                        else
                            pv = run_a[k] - 1;
                    end
                    send_req(OP_PROBE, pv, j == m - 1);
                    k += $urandom_range(0, 2);
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_req(OP_W'($urandom_range(3)), $urandom, 1'($urandom_range(1)));
            end
        end

        // full list: fill to capacity, overflow, then walk the whole merge
        send_req(OP_CLEAR, '0, 1'b0);
        acc = 64'($urandom_range(50));
        for (int i = 0; i < LIST_DEPTH; i++) begin
            full_a[i] = acc[VALUE_WIDTH-1:0];
            send_req(OP_APPEND, full_a[i], 1'b0);
            acc += $urandom_range(1, 3);
        end
        repeat (3)
            send_req(OP_APPEND, $urandom, 1'b0);
        idx = 3;
        while (idx < LIST_DEPTH) begin
            pv = full_a[idx];
            if ($urandom_range(3) == 0)
                pv = pv - 1;
            send_req(OP_PROBE, pv, 1'b0);
            idx += $urandom_range(20, 60);
        end
        send_req(OP_PROBE, full_a[LIST_DEPTH-1], 1'b0);
        send_req(OP_PROBE, full_a[LIST_DEPTH-1] + 1, 1'b1);
        send_req(OP_CLEAR, '0, 1'b0);
        send_req(OP_PROBE, '0, 1'b1);

        drain();
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_hits.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/sli_pkg.sv
design/sli_list_mem.sv
design/sli_merge_ctrl.sv
design/sorted_list_intersection_top.sv
design/sli_checker.sv
tb/tb.sv
